>>> src/scip2_pkg.sv
package scip2_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int MAX_LINES   = 64;

    localparam int LINE_W = $clog2(MAX_LINES + 2);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int CHAR_W = 7;

    localparam logic [LINE_W-1:0] LINE_ECHO   = LINE_W'(0);
    localparam logic [LINE_W-1:0] LINE_STATUS = LINE_W'(1);
    localparam logic [LINE_W-1:0] LINE_STAMP  = LINE_W'(2);
    localparam logic [LINE_W-1:0] LINE_DATA   = LINE_W'(3);
    localparam logic [LINE_W-1:0] LINE_LIMIT  = LINE_W'(MAX_LINES);

    localparam logic [CNT_W-1:0] SAMPLE_LIMIT = CNT_W'(MAX_SAMPLES);

    localparam logic [CHAR_W-1:0] CHAR_MAX    = 7'd127;
    localparam logic [CHAR_W-1:0] SCAN_POS_HI = 7'd13;
    localparam logic [CHAR_W-1:0] SCAN_POS_LO = 7'd14;

    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_M        = 8'h4D;
    localparam logic [7:0] CH_S        = 8'h53;
    localparam logic [7:0] CH_R        = 8'h52;
    localparam logic [7:0] CH_Q        = 8'h51;
    localparam logic [7:0] CH_T        = 8'h54;
    localparam logic [7:0] CH_B        = 8'h42;
    localparam logic [7:0] SUM_OFS     = 8'h30;

    localparam logic KIND_RANGE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        CMD_UNKNOWN = 3'd0,
        CMD_MS      = 3'd1,
        CMD_RS      = 3'd2,
        CMD_QT      = 3'd3,
        CMD_BM      = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_COMMAND    = 3'd1,
        ERR_STATUS_SUM = 3'd2,
        ERR_TIME_SUM   = 3'd3,
        ERR_DATA_SUM   = 3'd4,
        ERR_OVERFLOW   = 3'd5
    } err_t;

    typedef struct packed {
        logic        result_kind;
        logic [11:0] range_value;
        logic [9:0]  sample_index;
        logic [6:0]  status_code;
        logic [6:0]  scans_left;
        logic [23:0] time_stamp;
        logic [2:0]  error_code;
        logic [10:0] sample_total;
        logic        has_data;
    } res_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [6:0] dec1(input logic [7:0] c);
        return is_digit(c) ? {3'b000, c[3:0]} : 7'd0;
    endfunction

    function automatic logic [6:0] dec2(input logic [7:0] a, input logic [7:0] b);
        logic [6:0] ta;
        logic [6:0] tb;
        logic [6:0] res;
        ta = {3'b000, a[3:0]};
        tb = {3'b000, b[3:0]};
        if (is_digit(a))
        begin
            res = is_digit(b) ? (ta << 3) + (ta << 1) + tb : ta;
        end
        else if (a == CH_SPACE || (a >= CH_TAB && a <= CH_CR) || a == CH_PLUS)
        begin
            res = dec1(b);
        end
        else
        begin
            res = 7'd0;
        end
        return res;
    endfunction

    function automatic logic [5:0] six(input logic [7:0] c);
        logic [7:0] d;
        d = c - CH_ZERO;
        return d[5:0];
    endfunction

endpackage

>>> src/scip2_in_if.sv
interface scip2_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

>>> src/scip2_out_if.sv
interface scip2_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [11:0] range_value;
    logic [9:0]  sample_index;
    logic [6:0]  status_code;
    logic [6:0]  scans_left;
    logic [23:0] time_stamp;
    logic [2:0]  error_code;
    logic [10:0] sample_total;
    logic        has_data;

    modport source (
        output valid, output result_kind, output range_value, output sample_index,
        output status_code, output scans_left, output time_stamp, output error_code,
        output sample_total, output has_data, input ready
    );
    modport sink (
        input valid, input result_kind, input range_value, input sample_index,
        input status_code, input scans_left, input time_stamp, input error_code,
        input sample_total, input has_data, output ready
    );
endinterface

>>> src/scip2_in_reg.sv
module scip2_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    scip2_in_if.sink   rx,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       load;

    assign rx.ready = !valid_reg || advance;
    assign load     = rx.valid && rx.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= rx.rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

>>> src/scip2_parse.sv
module scip2_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        c,
    output logic              res_valid,
    output scip2_pkg::res_t   res
);

    logic [scip2_pkg::LINE_W-1:0] line_reg, line_next;
    logic [scip2_pkg::CHAR_W-1:0] char_reg, char_next;
    logic [5:0]                   sum_reg, sum_next;
    logic [7:0]                   held_reg, held_next;
    logic                         pair_reg, pair_next;
    logic                         prev_lf_reg, prev_lf_next;
    logic [7:0]                   first_reg, first_next;
    scip2_pkg::cmd_t              cmd_reg, cmd_next;
    logic [6:0]                   scans_reg, scans_next;
    logic [6:0]                   status_reg, status_next;
    logic [23:0]                  stamp_reg, stamp_next;
    scip2_pkg::err_t              err_reg, err_next;
    logic [scip2_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    logic [5:0]      sum_upd;
    logic [7:0]      sum_chk;
    scip2_pkg::err_t err_eff;

    always_comb
    begin
        line_next    = line_reg;
        char_next    = char_reg;
        sum_next     = sum_reg;
        held_next    = held_reg;
        pair_next    = pair_reg;
        prev_lf_next = prev_lf_reg;
        first_next   = first_reg;
        cmd_next     = cmd_reg;
        scans_next   = scans_reg;
        status_next  = status_reg;
        stamp_next   = stamp_reg;
        err_next     = err_reg;
        cnt_next     = cnt_reg;
        res_valid    = 1'b0;
        res          = '0;
        err_eff      = err_reg;

        sum_upd = (char_reg != '0) ? sum_reg + held_reg[5:0] : sum_reg;
        sum_chk = {2'b00, sum_upd} + scip2_pkg::SUM_OFS;

        if (step)
        begin
            if (c == scip2_pkg::CH_LF)
            begin
                if (prev_lf_reg)
                begin
                    res_valid        = 1'b1;
                    res.result_kind  = scip2_pkg::KIND_SUMMARY;
                    res.status_code  = status_reg;
                    res.scans_left   = (err_reg == scip2_pkg::ERR_NONE) ? scans_reg : 7'd0;
                    res.time_stamp   = stamp_reg;
                    res.error_code   = err_reg;
                    res.sample_total = 11'(cnt_reg);
                    res.has_data     = (line_reg >= scip2_pkg::LINE_DATA);
                    line_next    = '0;
                    char_next    = '0;
                    sum_next     = '0;
                    held_next    = '0;
                    pair_next    = 1'b0;
                    prev_lf_next = 1'b0;
                    first_next   = '0;
                    cmd_next     = scip2_pkg::CMD_UNKNOWN;
                    scans_next   = '0;
                    status_next  = '0;
                    stamp_next   = '0;
                    err_next     = scip2_pkg::ERR_NONE;
                    cnt_next     = '0;
                end
                else
                begin
                    if (err_reg == scip2_pkg::ERR_NONE)
                    begin
                        priority if (line_reg == scip2_pkg::LINE_ECHO)
                        begin
                            if (cmd_reg == scip2_pkg::CMD_UNKNOWN)
                            begin
                                err_next = scip2_pkg::ERR_COMMAND;
                            end
                        end
                        else if (line_reg == scip2_pkg::LINE_STATUS)
                        begin
                            if (char_reg < 7'd3)
                            begin
                                err_next = scip2_pkg::ERR_STATUS_SUM;
                            end
                        end
                        else if (line_reg == scip2_pkg::LINE_STAMP)
                        begin
                            if (char_reg < 7'd5)
                            begin
                                err_next = scip2_pkg::ERR_TIME_SUM;
                            end
                        end
                        else
                        begin
                            if (held_reg != {2'b00, sum_reg} + scip2_pkg::SUM_OFS)
                            begin
                                err_next = scip2_pkg::ERR_DATA_SUM;
                            end
                        end
                    end
                    if (line_reg <= scip2_pkg::LINE_LIMIT)
                    begin
                        line_next = line_reg + 1'b1;
                    end
                    char_next    = '0;
                    sum_next     = '0;
                    held_next    = '0;
                    pair_next    = 1'b0;
                    prev_lf_next = 1'b1;
                end
            end
            else
            begin
                prev_lf_next = 1'b0;
                if (char_reg == '0 && line_reg > scip2_pkg::LINE_LIMIT)
                begin
                    err_eff = scip2_pkg::ERR_OVERFLOW;
                end
                err_next  = err_eff;
                sum_next  = sum_upd;
                held_next = c;
                if (char_reg != scip2_pkg::CHAR_MAX)
                begin
                    char_next = char_reg + 1'b1;
                end
                if (err_eff == scip2_pkg::ERR_NONE)
                begin
                    priority if (line_reg == scip2_pkg::LINE_ECHO)
                    begin
                        if (char_reg == 7'd0)
                        begin
                            first_next = c;
                        end
                        else if (char_reg == 7'd1)
                        begin
                            priority if (first_reg == scip2_pkg::CH_M && c == scip2_pkg::CH_S)
                                cmd_next = scip2_pkg::CMD_MS;
                            else if (first_reg == scip2_pkg::CH_R && c == scip2_pkg::CH_S)
                                cmd_next = scip2_pkg::CMD_RS;
                            else if (first_reg == scip2_pkg::CH_Q && c == scip2_pkg::CH_T)
                                cmd_next = scip2_pkg::CMD_QT;
                            else if (first_reg == scip2_pkg::CH_B && c == scip2_pkg::CH_M)
                                cmd_next = scip2_pkg::CMD_BM;
                            else
                                cmd_next = scip2_pkg::CMD_UNKNOWN;
                        end
                        else if (cmd_reg == scip2_pkg::CMD_MS)
                        begin
                            if (char_reg == scip2_pkg::SCAN_POS_HI)
                            begin
                                scans_next = scip2_pkg::dec1(c);
                            end
                            else if (char_reg == scip2_pkg::SCAN_POS_LO)
                            begin
                                scans_next = scip2_pkg::dec2(held_reg, c);
                            end
                        end
                    end
                    else if (line_reg == scip2_pkg::LINE_STATUS)
                    begin
                        if (char_reg == 7'd0)
                        begin
                            status_next = scip2_pkg::dec1(c);
                        end
                        else if (char_reg == 7'd1)
                        begin
                            status_next = scip2_pkg::dec2(held_reg, c);
                        end
                        else if (char_reg == 7'd2 && c != sum_chk)
                        begin
                            err_next = scip2_pkg::ERR_STATUS_SUM;
                        end
                    end
                    else if (line_reg == scip2_pkg::LINE_STAMP)
                    begin
                        if (char_reg < 7'd4)
                        begin
                            stamp_next = {stamp_reg[17:0], scip2_pkg::six(c)};
                        end
                        else if (char_reg == 7'd4 && c != sum_chk)
                        begin
                            err_next = scip2_pkg::ERR_TIME_SUM;
                        end
                    end
                    else
                    begin
                        if (pair_reg)
                        begin
                            pair_next = 1'b0;
                            if (cnt_reg >= scip2_pkg::SAMPLE_LIMIT)
                            begin
                                err_next = scip2_pkg::ERR_OVERFLOW;
                            end
                            else
                            begin
                                res_valid        = 1'b1;
                                res.result_kind  = scip2_pkg::KIND_RANGE;
                                res.range_value  = {scip2_pkg::six(held_reg), scip2_pkg::six(c)};
                                res.sample_index = 10'(cnt_reg);
                                cnt_next         = cnt_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            pair_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg    <= '0;
            char_reg    <= '0;
            sum_reg     <= '0;
            held_reg    <= '0;
            pair_reg    <= 1'b0;
            prev_lf_reg <= 1'b0;
            first_reg   <= '0;
            cmd_reg     <= scip2_pkg::CMD_UNKNOWN;
            scans_reg   <= '0;
            status_reg  <= '0;
            stamp_reg   <= '0;
            err_reg     <= scip2_pkg::ERR_NONE;
            cnt_reg     <= '0;
        end
        else
        begin
            line_reg    <= line_next;
            char_reg    <= char_next;
            sum_reg     <= sum_next;
            held_reg    <= held_next;
            pair_reg    <= pair_next;
            prev_lf_reg <= prev_lf_next;
            first_reg   <= first_next;
            cmd_reg     <= cmd_next;
            scans_reg   <= scans_next;
            status_reg  <= status_next;
            stamp_reg   <= stamp_next;
            err_reg     <= err_next;
            cnt_reg     <= cnt_next;
        end
    end

endmodule

>>> src/scip2_out_reg.sv
module scip2_out_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            res_valid,
    input  scip2_pkg::res_t res,
    output logic            free,
    scip2_out_if.source     result
);

    logic            valid_reg;
    logic            valid_next;
    scip2_pkg::res_t data_reg;

    assign free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = res_valid;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign result.valid        = valid_reg;
    assign result.result_kind  = data_reg.result_kind;
    assign result.range_value  = data_reg.range_value;
    assign result.sample_index = data_reg.sample_index;
    assign result.status_code  = data_reg.status_code;
    assign result.scans_left   = data_reg.scans_left;
    assign result.time_stamp   = data_reg.time_stamp;
    assign result.error_code   = data_reg.error_code;
    assign result.sample_total = data_reg.sample_total;
    assign result.has_data     = data_reg.has_data;

endmodule

>>> src/scip2_response_deframer.sv
// path: a byte goes from the input register through the parse step into the result register
// throughput: one byte per cycle while the result register is free, limited by the single
// parse step between the input register and the result register
// reset (rst_n, async, active low) empties both registers and clears all parse state
// parse state also clears after every end-of-message summary
module scip2_response_deframer (
    input  logic        clk,
    input  logic        rst_n,
    scip2_in_if.sink    rx,
    scip2_out_if.source result
);

    logic            byte_valid;
    logic [7:0]      byte_data;
    logic            free;
    logic            advance;
    logic            res_valid;
    scip2_pkg::res_t res;

    assign advance = byte_valid && free;

    scip2_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    scip2_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .c         (byte_data),
        .res_valid (res_valid),
        .res       (res)
    );

    scip2_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res),
        .free      (free),
        .result    (result)
    );

endmodule
